// ===== sv/pf6_pkg.sv =====
`default_nettype none
package pf6_pkg;

  localparam int SIDE  = 6;
  localparam int NSYM  = SIDE * SIDE;
  localparam int SYM_W = $clog2(NSYM);

  localparam logic [SYM_W-1:0] SYM_X    = SYM_W'(23);
  localparam logic [SYM_W-1:0] SYM_NONE = '1;
  localparam logic [7:0]       CHAR_SPACE = 8'd32;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_FIN = 2'd1,
    OP_MSG = 2'd2,
    OP_END = 2'd3
  } pf6_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SPACE,
    ST_RDA,
    ST_RDB,
    ST_CALC,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_EMA,
    ST_EMB
  } pf6_state_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pf6_rc_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90) return 8'(c + 8'd32);
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] to_symbol(input logic [7:0] c);
    if (c >= 8'd97 && c <= 8'd122) return SYM_W'(c - 8'd97);
    if (c >= 8'd48 && c <= 8'd57)  return SYM_W'(c - 8'd48 + 8'd26);
    return SYM_NONE;
  endfunction

  function automatic logic [7:0] to_ascii(input logic [SYM_W-1:0] s);
    if (s < SYM_W'(26)) return 8'(8'd97 + 8'(s));
    return 8'(8'd48 + 8'(s) - 8'd26);
  endfunction

  // cell index to row/column: row = (p * 43) >> 8 is exact for p < 36
  function automatic pf6_rc_t split_cell(input logic [SYM_W-1:0] p);
    logic [11:0] prod;
    pf6_rc_t     rc;
    prod   = 12'(p) * 12'd43;
    rc.row = prod[10:8];
    rc.col = 3'(p - SYM_W'(rc.row) * SYM_W'(SIDE));
    return rc;
  endfunction

  function automatic logic [SYM_W-1:0] join_cell(input pf6_rc_t rc);
    return SYM_W'(SYM_W'(rc.row) * SYM_W'(SIDE) + SYM_W'(rc.col));
  endfunction

endpackage
`default_nettype wire

// ===== sv/pf6_ram.sv =====
`default_nettype none
module pf6_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/pf6_pair_calc.sv =====
`default_nettype none
module pf6_pair_calc import pf6_pkg::*; (
  input  wire logic [SYM_W-1:0] pa,
  input  wire logic [SYM_W-1:0] pb,
  input  wire logic             dec,
  output      logic [SYM_W-1:0] ca,
  output      logic [SYM_W-1:0] cb
);

  pf6_rc_t a, b, oa, ob;

  function automatic logic [2:0] shift6(input logic [2:0] v, input logic d);
    if (d) return (v == 3'd0) ? 3'(SIDE - 1) : 3'(v - 3'd1);
    return (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  always_comb begin
    a  = split_cell(pa);
    b  = split_cell(pb);
    oa = a;
    ob = b;
    if (a.row == b.row) begin
      oa.col = shift6(a.col, dec);
      ob.col = shift6(b.col, dec);
    end else if (a.col == b.col) begin
      oa.row = shift6(a.row, dec);
      ob.row = shift6(b.row, dec);
    end else begin
      // rectangle: swap columns
      oa.col = b.col;
      ob.col = a.col;
    end
    ca = join_cell(oa);
    cb = join_cell(ob);
  end

endmodule
`default_nettype wire

// ===== sv/playfair_6x6_cipher_unit.sv =====
// Sequence: a new key character is appended as it is accepted; finish sweeps
//   all 36 symbols, one symbol per cycle; a space word waits in ST_SPACE.
// Throughput: one item at a time; a pair runs RDA, RDB, CALC, KA, KB, KC, EMA, EMB,
//   plus any output stall; each table has one read port (position, square lookup).
// Reset: synchronous, active low; clears key state, pending half pair, mode
//   and output valid. Square tables are undefined until a finish.
`default_nettype none
module playfair_6x6_cipher_unit import pf6_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic [1:0] in_tuser,   // [1:0] opcode
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] char_out
  output      logic       out_tlast,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [0:0] cfg_data    // [0] decrypt_mode
);

  pf6_state_t       state_r, state_nxt;
  logic [NSYM-1:0]  used_r, used_nxt, used_eff;
  logic [SYM_W-1:0] fill_r, fill_nxt, fill_eff;
  logic             ready_r, ready_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0] pend_s_r, pend_s_nxt;
  logic [SYM_W-1:0] idx_r, idx_nxt;
  logic [SYM_W-1:0] a_r, a_nxt, b_r, b_nxt, pa_r, pa_nxt;
  logic [SYM_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt, oa_r, oa_nxt, ob_r, ob_nxt;
  logic             ov_r, ov_nxt, olast_r, olast_nxt;
  logic [7:0]       odata_r, odata_nxt;
  logic             dec_r;

  logic             in_acc, slot_free, app_req, app_ok;
  logic [SYM_W-1:0] app_sym, in_sym;
  logic [7:0]       in_ch;
  logic [NSYM-1:0]  app_mask;
  pf6_op_t          op;

  logic [SYM_W-1:0] pos_raddr, pos_rdata, ks_raddr, ks_rdata, calc_a, calc_b;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign slot_free  = !ov_r || out_tready;

  assign op     = pf6_op_t'(in_tuser);
  assign in_ch  = lower_ascii(in_tdata);
  assign in_sym = to_symbol(in_ch);

  // shared append unit: key characters and the finish sweep
  assign app_sym  = (state_r == ST_FILL) ? idx_r : in_sym;
  assign used_eff = (state_r == ST_IDLE && ready_r) ? '0 : used_r;
  assign fill_eff = (state_r == ST_IDLE && ready_r) ? '0 : fill_r;
  assign app_mask = NSYM'(1) << app_sym;
  assign app_ok   = app_req && (app_sym < SYM_W'(NSYM)) && (fill_eff < SYM_W'(NSYM))
                    && !(|(used_eff & app_mask));

  pf6_ram #(.WIDTH(SYM_W), .DEPTH(NSYM)) u_pos_ram (
    .clk(clk), .we(app_ok), .waddr(app_sym), .wdata(fill_eff),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  pf6_ram #(.WIDTH(SYM_W), .DEPTH(NSYM)) u_ks_ram (
    .clk(clk), .we(app_ok), .waddr(fill_eff), .wdata(app_sym),
    .raddr(ks_raddr), .rdata(ks_rdata)
  );

  pf6_pair_calc u_calc (
    .pa(pa_r), .pb(pos_rdata), .dec(dec_r), .ca(calc_a), .cb(calc_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      fill_r   <= '0;
      ready_r  <= 1'b0;
      pend_v_r <= 1'b0;
      pend_s_r <= '0;
      ov_r     <= 1'b0;
      dec_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      fill_r   <= fill_nxt;
      ready_r  <= ready_nxt;
      pend_v_r <= pend_v_nxt;
      pend_s_r <= pend_s_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid && cfg_ready) dec_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    pa_r    <= pa_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    fill_nxt   = fill_r;
    ready_nxt  = ready_r;
    pend_v_nxt = pend_v_r;
    pend_s_nxt = pend_s_r;
    idx_nxt    = idx_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pa_nxt     = pa_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    oa_nxt     = oa_r;
    ob_nxt     = ob_r;
    ov_nxt     = ov_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    app_req    = 1'b0;
    pos_raddr  = a_r;
    ks_raddr   = ca_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_KEY: begin
              // reusing a finished square starts a fresh key
              app_req   = 1'b1;
              used_nxt  = used_eff;
              fill_nxt  = fill_eff;
              ready_nxt = 1'b0;
            end
            OP_FIN: begin
              pend_v_nxt = 1'b0;
              idx_nxt    = '0;
              state_nxt  = ST_FILL;
            end
            OP_MSG: begin
              if (ready_r) begin
                if (in_ch == CHAR_SPACE) begin
                  if (!pend_v_r) state_nxt = ST_SPACE;
                end else if (in_sym != SYM_NONE) begin
                  if (!pend_v_r) begin
                    pend_v_nxt = 1'b1;
                    pend_s_nxt = in_sym;
                  end else begin
                    a_nxt     = pend_s_r;
                    state_nxt = ST_RDA;
                    if (in_sym == pend_s_r) begin
                      b_nxt = SYM_X;      // doubled letter stays pending
                    end else begin
                      b_nxt      = in_sym;
                      pend_v_nxt = 1'b0;
                    end
                  end
                end
              end
            end
            OP_END: begin
              pend_v_nxt = 1'b0;
              if (ready_r && pend_v_r) begin
                a_nxt     = pend_s_r;
                b_nxt     = SYM_X;
                state_nxt = ST_RDA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        app_req = 1'b1;
        idx_nxt = SYM_W'(idx_r + SYM_W'(1));
        if (idx_r == SYM_W'(NSYM - 1)) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SPACE: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = CHAR_SPACE;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RDA: begin
        pos_raddr = a_r;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        pos_raddr = b_r;
        pa_nxt    = pos_rdata;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        ca_nxt    = calc_a;
        cb_nxt    = calc_b;
        state_nxt = ST_KA;
      end
      ST_KA: begin
        ks_raddr  = ca_r;
        state_nxt = ST_KB;
      end
      ST_KB: begin
        ks_raddr  = cb_r;
        oa_nxt    = ks_rdata;
        state_nxt = ST_KC;
      end
      ST_KC: begin
        ob_nxt    = ks_rdata;
        state_nxt = ST_EMA;
      end
      ST_EMA: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = to_ascii(oa_r);
          olast_nxt = 1'b0;
          state_nxt = ST_EMB;
        end
      end
      ST_EMB: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = to_ascii(ob_r);
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (app_ok) begin
      used_nxt = used_eff | app_mask;
      fill_nxt = SYM_W'(fill_eff + SYM_W'(1));
    end
  end

endmodule
`default_nettype wire

// ===== sv/pf6_checker.sv =====
`default_nettype none
module pf6_checker import pf6_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic       out_tlast
);

  // a stalled word is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // second word of a pair follows straight after the first is taken
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second word of a pair missing");

  // a key character never produces a word
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_KEY && !out_tvalid |=> !out_tvalid)
    else $error("key character produced output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind playfair_6x6_cipher_unit pf6_checker u_pf6_checker (.*);
`default_nettype wire
